### rtl/fasc_pkg.sv
// Package for the flight-aware sleep controller: transaction and register types,
// register indexes, sensor mode and sleep cause codes, and reset values.
// Depends on nothing; every other file of the block imports it.
package fasc_pkg;

  localparam int TIME_W   = 32;
  localparam int INACT_W  = 27;
  localparam int GRACE_W  = 22;
  localparam int LDELAY_W = 22;
  localparam int LIDLE_W  = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 27;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INACTIVITY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRACE         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LANDING_DELAY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LANDING_IDLE  = 2'd3;

  // Register reset values.
  localparam logic [INACT_W-1:0]  INACT_RESET  = 27'd0;
  localparam logic [GRACE_W-1:0]  GRACE_RESET  = 22'd120000;
  localparam logic [LDELAY_W-1:0] LDELAY_RESET = 22'd300000;
  localparam logic [LIDLE_W-1:0]  LIDLE_RESET  = 20'd10000;

  // Sensor mode codes.
  localparam logic [1:0] MODE_ECONOMY  = 2'd0;
  localparam logic [1:0] MODE_PRECISE  = 2'd1;
  localparam logic [1:0] MODE_FREEFALL = 2'd2;

  // Sleep cause codes.
  localparam logic [1:0] CAUSE_NONE       = 2'd0;
  localparam logic [1:0] CAUSE_LOW_BATT   = 2'd1;
  localparam logic [1:0] CAUSE_LANDING    = 2'd2;
  localparam logic [1:0] CAUSE_INACTIVITY = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [1:0]        sensor_mode;
    logic              in_jump;
    logic              menu_open;
    logic              game_running;
    logic              sleep_lock;
    logic              usb_present;
    logic              battery_low;
    logic              user_activity;
  } in_item_t;

  typedef struct packed {
    logic       sleep_request;
    logic [1:0] sleep_cause;
    logic       flight_blocked;
  } out_item_t;

  typedef struct packed {
    logic [INACT_W-1:0]  inactivity_timeout_ms;
    logic [GRACE_W-1:0]  grace_ms;
    logic [LDELAY_W-1:0] landing_delay_ms;
    logic [LIDLE_W-1:0]  landing_idle_ms;
  } cfg_regs_t;

endpackage

### rtl/fasc_cfg.sv
// Configuration register file of the sleep controller: four timing registers
// written through a plain write port. Depends on fasc_pkg.
module fasc_cfg
  import fasc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_regs_t             regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  // Decode the register index and take the low bits of the write data.
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_INACTIVITY:    regs_nxt.inactivity_timeout_ms = cfg_wdata[INACT_W-1:0];
        CFG_GRACE:         regs_nxt.grace_ms              = cfg_wdata[GRACE_W-1:0];
        CFG_LANDING_DELAY: regs_nxt.landing_delay_ms      = cfg_wdata[LDELAY_W-1:0];
        CFG_LANDING_IDLE:  regs_nxt.landing_idle_ms       = cfg_wdata[LIDLE_W-1:0];
        default:           regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.inactivity_timeout_ms <= INACT_RESET;
      regs_r.grace_ms              <= GRACE_RESET;
      regs_r.landing_delay_ms      <= LDELAY_RESET;
      regs_r.landing_idle_ms       <= LIDLE_RESET;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

### rtl/fasc_core.sv
// Decision core of the sleep controller: flight, grace and landing tracking,
// activity time, and the per-tick sleep decision. Depends on fasc_pkg.
module fasc_core
  import fasc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  input  cfg_regs_t regs,
  output out_item_t result
);

  logic [TIME_W-1:0] last_act_r, last_act_nxt;
  logic              was_flight_r, was_flight_nxt;
  logic              grace_armed_r, grace_armed_nxt;
  logic [TIME_W-1:0] grace_start_r, grace_start_nxt;
  logic              land_armed_r, land_armed_nxt;
  logic [TIME_W-1:0] land_start_r, land_start_nxt;
  logic [1:0]        prev_mode_r, prev_mode_nxt;

  logic              flight;
  logic              blocked;
  logic              batt_req;
  logic              tail_update;
  logic [TIME_W-1:0] grace_elapsed;
  logic [TIME_W-1:0] idle_elapsed;
  logic [TIME_W-1:0] land_elapsed;
  logic              landing_ok;
  logic              inact_ok;
  logic [1:0]        cause;

  // Flight and grace window; a window opened this tick starts at now_ms.
  always_comb begin
    flight          = (item.sensor_mode != MODE_ECONOMY) || item.in_jump;
    was_flight_nxt  = was_flight_r;
    grace_armed_nxt = grace_armed_r;
    grace_start_nxt = grace_start_r;
    if (flight) begin
      was_flight_nxt  = 1'b1;
      grace_armed_nxt = 1'b0;
    end else if (was_flight_r) begin
      grace_armed_nxt = 1'b1;
      grace_start_nxt = item.now_ms;
      was_flight_nxt  = 1'b0;
    end
    grace_elapsed = item.now_ms - grace_start_nxt;
    blocked  = flight || (grace_armed_nxt &&
               (grace_elapsed < {{(TIME_W-GRACE_W){1'b0}}, regs.grace_ms}));
    batt_req = !blocked && item.battery_low;
    // A low battery request skips the landing and activity updates.
    tail_update = !batt_req;
  end

  // Landing timer, mode history and activity time.
  always_comb begin
    land_armed_nxt = land_armed_r;
    land_start_nxt = land_start_r;
    prev_mode_nxt  = prev_mode_r;
    last_act_nxt   = last_act_r;
    if (tail_update) begin
      if (prev_mode_r != MODE_ECONOMY && item.sensor_mode == MODE_ECONOMY) begin
        land_armed_nxt = 1'b1;
        land_start_nxt = item.now_ms;
      end
      if (prev_mode_r == MODE_ECONOMY && item.sensor_mode != MODE_ECONOMY) begin
        land_armed_nxt = 1'b0;
      end
      prev_mode_nxt = item.sensor_mode;
      if (item.user_activity || (!blocked && item.usb_present)) begin
        last_act_nxt = item.now_ms;
      end
    end
  end

  // Sleep decision: low battery, then landing, then inactivity.
  always_comb begin
    idle_elapsed = item.now_ms - last_act_nxt;
    land_elapsed = item.now_ms - land_start_nxt;
    landing_ok   = land_armed_nxt &&
                   (idle_elapsed >= {{(TIME_W-LIDLE_W){1'b0}}, regs.landing_idle_ms}) &&
                   (land_elapsed >= {{(TIME_W-LDELAY_W){1'b0}}, regs.landing_delay_ms});
    inact_ok     = (regs.inactivity_timeout_ms != '0) &&
                   (idle_elapsed >= {{(TIME_W-INACT_W){1'b0}}, regs.inactivity_timeout_ms});
    if (batt_req) begin
      cause = CAUSE_LOW_BATT;
    end else if (blocked || item.usb_present || item.menu_open ||
                 item.game_running || item.sleep_lock) begin
      cause = CAUSE_NONE;
    end else if (landing_ok) begin
      cause = CAUSE_LANDING;
    end else if (inact_ok) begin
      cause = CAUSE_INACTIVITY;
    end else begin
      cause = CAUSE_NONE;
    end
    result.sleep_request  = (cause != CAUSE_NONE);
    result.sleep_cause    = cause;
    result.flight_blocked = blocked;
  end

  // State advances only when a transaction is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_act_r    <= '0;
      was_flight_r  <= 1'b0;
      grace_armed_r <= 1'b0;
      grace_start_r <= '0;
      land_armed_r  <= 1'b0;
      land_start_r  <= '0;
      prev_mode_r   <= MODE_ECONOMY;
    end else if (fire) begin
      last_act_r    <= last_act_nxt;
      was_flight_r  <= was_flight_nxt;
      grace_armed_r <= grace_armed_nxt;
      grace_start_r <= grace_start_nxt;
      land_armed_r  <= land_armed_nxt;
      land_start_r  <= land_start_nxt;
      prev_mode_r   <= prev_mode_nxt;
    end
  end

`ifndef SYNTHESIS
  // A flight tick always leaves the flight flag set and the grace window closed.
  a_flight_state: assert property (@(posedge clk) disable iff (!rst_n)
    fire && flight |=> was_flight_r && !grace_armed_r)
    else $error("flight tick did not record flight state");

  // A processed tick leaves its own mode as the remembered mode unless a
  // low battery request skipped the update.
  a_mode_track: assert property (@(posedge clk) disable iff (!rst_n)
    fire && tail_update |=> prev_mode_r == $past(item.sensor_mode))
    else $error("mode history not updated");

  // Blocked ticks never produce a landing or inactivity cause.
  a_block_cause: assert property (@(posedge clk) disable iff (!rst_n)
    blocked |-> (cause == CAUSE_NONE))
    else $error("sleep cause raised while blocked");
`endif

endmodule

### rtl/flight_aware_sleep_controller.sv
// Top level of the flight-aware sleep controller: input register, decision
// core, result register and configuration registers. Depends on fasc_pkg,
// fasc_cfg and fasc_core.
//
//   Channel   Ports                           Contents
//   input     in_valid / in_ready / in_data   one tick (in_item_t)
//   result    out_valid / out_ready / out_data one decision (out_item_t)
//   config    cfg_we / cfg_index / cfg_wdata  register writes, no wait state
//
// A tick waits in the input register while the decision logic works on it and
// moves to the result register once the result side can take it. One tick is
// accepted per cycle unless the result stalls; core state updates in a single pass.
// Reset is synchronous and active low; it empties both registers and
// restores the register reset values and the tracking state.
// A stalled result holds both registers, so in_ready falls only when both are full.
module flight_aware_sleep_controller
  import fasc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_regs_t regs;
  in_item_t  in_item_r;
  logic      in_valid_r, in_valid_nxt;
  out_item_t out_item_r;
  out_item_t result;
  logic      out_valid_r, out_valid_nxt;
  logic      advance;

  fasc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  fasc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (in_item_r),
    .regs   (regs),
    .result (result)
  );

  // Handshake control for the two stages.
  always_comb begin
    advance       = in_valid_r && (!out_valid_r || out_ready);
    in_ready      = !in_valid_r || advance;
    in_valid_nxt  = (in_valid && in_ready) || (in_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

`ifndef SYNTHESIS
  // A waiting tick is never dropped while the result side stalls.
  a_hold_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r)
    else $error("pending tick lost");

  // A processed tick always shows up in the result register.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed tick produced no result");

  // The request flag agrees with the cause field.
  a_req_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.sleep_request == (out_item_r.sleep_cause != CAUSE_NONE)))
    else $error("sleep request and cause disagree");
`endif

endmodule

### verif/fasc_checker.sv
// Checker for the flight-aware sleep controller: watches the tick, result and
// register ports, predicts every sleep decision and compares it field by field.
// Depends on fasc_pkg for the transaction types, register indexes and codes.
module fasc_checker
  import fasc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    checked_count,
  output int                    low_batt_count,
  output int                    landing_count,
  output int                    inactivity_count,
  output int                    blocked_count
);

  // Register copy and tracking state of the predicted controller.
  cfg_regs_t         limits;
  logic [TIME_W-1:0] last_act_ms;
  logic              was_flying;
  logic              grace_open;
  logic [TIME_W-1:0] grace_t0;
  logic              landing_open;
  logic [TIME_W-1:0] landing_t0;
  logic [1:0]        last_mode;

  // Decisions predicted for accepted ticks, oldest first.
  out_item_t decisions_due[$];

  initial begin
    fail_count       = 0;
    checked_count    = 0;
    low_batt_count   = 0;
    landing_count    = 0;
    inactivity_count = 0;
    blocked_count    = 0;
  end

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // Works out the decision for one tick and advances the tracking state.
  function automatic out_item_t decide_sleep(input in_item_t tick);
    logic              flight;
    logic              blocked;
    logic [1:0]        cause;
    logic [TIME_W-1:0] since_grace;
    logic [TIME_W-1:0] idle_ms;
    logic [TIME_W-1:0] since_landing;
    out_item_t         res;
    flight = (tick.sensor_mode != MODE_ECONOMY) || tick.in_jump;
    // Flight context: leaving flight opens the grace window.
    if (flight) begin
      was_flying = 1'b1;
      grace_open = 1'b0;
    end else if (was_flying) begin
      grace_open = 1'b1;
      grace_t0   = tick.now_ms;
      was_flying = 1'b0;
    end
    since_grace = tick.now_ms - grace_t0;
    blocked = flight || (grace_open && (since_grace < TIME_W'(limits.grace_ms)));
    cause = CAUSE_NONE;
    if (!blocked && tick.battery_low) begin
      // A low battery request skips the landing timer and activity updates.
      cause = CAUSE_LOW_BATT;
    end else begin
      if (last_mode != MODE_ECONOMY && tick.sensor_mode == MODE_ECONOMY) begin
        landing_open = 1'b1;
        landing_t0   = tick.now_ms;
      end
      if (last_mode == MODE_ECONOMY && tick.sensor_mode != MODE_ECONOMY) begin
        landing_open = 1'b0;
      end
      last_mode = tick.sensor_mode;
      if (tick.user_activity) begin
        last_act_ms = tick.now_ms;
      end
      idle_ms       = tick.now_ms - last_act_ms;
      since_landing = tick.now_ms - landing_t0;
      if (blocked) begin
        cause = CAUSE_NONE;
      end else if (tick.usb_present) begin
        // External power counts as activity and keeps the unit awake.
        last_act_ms = tick.now_ms;
      end else if (tick.menu_open || tick.game_running || tick.sleep_lock) begin
        cause = CAUSE_NONE;
      end else if (landing_open && idle_ms >= TIME_W'(limits.landing_idle_ms) &&
                   since_landing >= TIME_W'(limits.landing_delay_ms)) begin
        cause = CAUSE_LANDING;
      end else if (limits.inactivity_timeout_ms != '0 &&
                   idle_ms >= TIME_W'(limits.inactivity_timeout_ms)) begin
        cause = CAUSE_INACTIVITY;
      end
    end
    res.sleep_request  = (cause != CAUSE_NONE);
    res.sleep_cause    = cause;
    res.flight_blocked = blocked;
    return res;
  endfunction

  // Compares finished transactions, then predicts new ones and tracks writes.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      limits.inactivity_timeout_ms = INACT_RESET;
      limits.grace_ms              = GRACE_RESET;
      limits.landing_delay_ms      = LDELAY_RESET;
      limits.landing_idle_ms       = LIDLE_RESET;
      last_act_ms  = '0;
      was_flying   = 1'b0;
      grace_open   = 1'b0;
      grace_t0     = '0;
      landing_open = 1'b0;
      landing_t0   = '0;
      last_mode    = MODE_ECONOMY;
      decisions_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (decisions_due.size() == 0) begin
          report_mismatch("result transaction with no tick waiting for it");
        end else begin
          want = decisions_due.pop_front();
          if (out_data.sleep_request !== want.sleep_request) begin
            report_mismatch($sformatf("sleep_request: got %b, expected %b",
                                      out_data.sleep_request, want.sleep_request));
          end
          if (out_data.sleep_cause !== want.sleep_cause) begin
            report_mismatch($sformatf("sleep_cause: got %0d, expected %0d",
                                      out_data.sleep_cause, want.sleep_cause));
          end
          if (out_data.flight_blocked !== want.flight_blocked) begin
            report_mismatch($sformatf("flight_blocked: got %b, expected %b",
                                      out_data.flight_blocked, want.flight_blocked));
          end
          case (want.sleep_cause)
            CAUSE_LOW_BATT:   low_batt_count++;
            CAUSE_LANDING:    landing_count++;
            CAUSE_INACTIVITY: inactivity_count++;
            default:          ;
          endcase
          if (want.flight_blocked) begin
            blocked_count++;
          end
          checked_count++;
        end
      end
      if (in_valid && in_ready) begin
        decisions_due.push_back(decide_sleep(in_data));
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_INACTIVITY:    limits.inactivity_timeout_ms = cfg_wdata[INACT_W-1:0];
          CFG_GRACE:         limits.grace_ms              = cfg_wdata[GRACE_W-1:0];
          CFG_LANDING_DELAY: limits.landing_delay_ms      = cfg_wdata[LDELAY_W-1:0];
          CFG_LANDING_IDLE:  limits.landing_idle_ms       = cfg_wdata[LIDLE_W-1:0];
          default:           ;
        endcase
      end
    end
  end

endmodule

### verif/tb_flight_aware_sleep_controller.sv
// Top of the flight-aware sleep controller testbench: clock, reset, register
// settings, tick stimulus with flight profiles and result back-pressure.
// Depends on fasc_pkg, the block and fasc_checker.
module tb_flight_aware_sleep_controller;
  import fasc_pkg::*;

  localparam int N_PHASES      = 8;
  localparam int PHASE_TICKS   = 225;
  localparam int QUIET_PHASE   = 3;
  localparam int RANDOM_PHASE  = 6;
  localparam int HOLD_CYCLES   = 60;
  localparam int HOLD_AFTER    = 300;
  localparam int DRAIN_CYCLES  = 8;
  localparam int WATCHDOG_TIME = 2000000;
  // Mode code that the block does not name; it still counts as flight.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic OFF = 1'b0;
  localparam logic ON  = 1'b1;

  // Register settings per phase: all zero, small, large, one, mixed, mixed, random, reset with inactivity on.
  int unsigned phase_inact [N_PHASES] = '{0, 3000, 86400000, 1, 15000, 7000, 0, 60000};
  int unsigned phase_grace [N_PHASES] = '{0, 800, 3600000, 1, 5000, 0, 0, 32'(GRACE_RESET)};
  int unsigned phase_delay [N_PHASES] = '{0, 2000, 3600000, 1, 0, 4000, 0, 32'(LDELAY_RESET)};
  int unsigned phase_idle  [N_PHASES] = '{0, 500, 600000, 1, 2000, 0, 0, 32'(LIDLE_RESET)};

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int checked_count;
  int low_batt_count;
  int landing_count;
  int inactivity_count;
  int blocked_count;
  int sent_count;

  logic [TIME_W-1:0] clock_ms;
  int unsigned       unit_ms;
  logic              tx_gaps;
  logic              rx_gaps;

  flight_aware_sleep_controller u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fasc_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .checked_count    (checked_count),
    .low_batt_count   (low_batt_count),
    .landing_count    (landing_count),
    .inactivity_count (inactivity_count),
    .blocked_count    (blocked_count)
  );

  // Free-running clock with a period of ten time units.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Ends a run that has hung.
  initial begin : watchdog
    #(WATCHDOG_TIME);
    $display("Timeout: %0d ticks sent, %0d results checked", sent_count, checked_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off that fills the block.
  initial begin : result_sink
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && checked_count >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= !(rx_gaps && $urandom_range(99) < 23);
    end
  end

  function automatic in_item_t make_tick(input logic [TIME_W-1:0] now, input logic [1:0] mode,
                                         input logic jump, input logic menu, input logic game,
                                         input logic lock, input logic usb, input logic batt,
                                         input logic act);
    in_item_t tick;
    tick.now_ms        = now;
    tick.sensor_mode   = mode;
    tick.in_jump       = jump;
    tick.menu_open     = menu;
    tick.game_running  = game;
    tick.sleep_lock    = lock;
    tick.usb_present   = usb;
    tick.battery_low   = batt;
    tick.user_activity = act;
    return tick;
  endfunction

  // Offers one tick transaction, with random gaps ahead of it.
  task automatic send_tick(input in_item_t tick);
    while (tx_gaps && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= tick;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // Stops offering and waits until every tick has its result checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (checked_count != sent_count);
  endtask

  // Writes all four registers once the block is idle, and sets the time scale.
  task automatic apply_setting(input int unsigned inact, input int unsigned grace,
                               input int unsigned ldelay, input int unsigned lidle);
    int unsigned longest;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INACTIVITY;
    cfg_wdata <= CFG_DATA_W'(inact);
    @(posedge clk);
    cfg_index <= CFG_GRACE;
    cfg_wdata <= CFG_DATA_W'(grace);
    @(posedge clk);
    cfg_index <= CFG_LANDING_DELAY;
    cfg_wdata <= CFG_DATA_W'(ldelay);
    @(posedge clk);
    cfg_index <= CFG_LANDING_IDLE;
    cfg_wdata <= CFG_DATA_W'(lidle);
    @(posedge clk);
    cfg_we <= 1'b0;
    longest = inact;
    if (grace > longest) longest = grace;
    if (ldelay > longest) longest = ldelay;
    if (lidle > longest) longest = lidle;
    unit_ms = longest / 16 + 64;
  endtask

  // One tick with a time step scaled to the current setting and random flags.
  task automatic random_tick(input logic [1:0] mode, input logic jump, input int busy_pct);
    int unsigned roll;
    int unsigned step;
    roll = $urandom_range(99);
    if (roll < 60) begin
      step = $urandom_range(unit_ms);
    end else if (roll < 90) begin
      step = $urandom_range(4 * unit_ms);
    end else if (roll < 98) begin
      step = $urandom_range(40 * unit_ms);
    end else begin
      step = $urandom();
    end
    clock_ms = clock_ms + step;
    send_tick(make_tick(clock_ms, mode, jump,
                        $urandom_range(99) < busy_pct, $urandom_range(99) < busy_pct,
                        $urandom_range(99) < busy_pct, $urandom_range(99) < busy_pct,
                        $urandom_range(99) < busy_pct / 2,
                        $urandom_range(99) < busy_pct + 10));
  endtask

  // Mostly whole flights (climb, freefall, canopy, ground), some random noise.
  task automatic run_phase(input int n_ticks);
    int done;
    int climb;
    int fall;
    int canopy;
    int ground;
    int k;
    done = 0;
    while (done < n_ticks) begin
      if ($urandom_range(99) < 75) begin
        climb  = $urandom_range(1, 4);
        fall   = $urandom_range(1, 5);
        canopy = $urandom_range(1, 4);
        ground = $urandom_range(8, 30);
        for (k = 0; k < climb; k++) random_tick(MODE_PRECISE, 1'($urandom_range(1)), 50);
        for (k = 0; k < fall; k++) random_tick(MODE_FREEFALL, ON, 50);
        for (k = 0; k < canopy; k++) random_tick(MODE_PRECISE, 1'($urandom_range(1)), 50);
        for (k = 0; k < ground; k++) begin
          random_tick(MODE_ECONOMY, $urandom_range(99) < 3, 6);
        end
        done += climb + fall + canopy + ground;
      end else begin
        k = $urandom_range(1, 6);
        done += k;
        repeat (k) random_tick(2'($urandom_range(3)), 1'($urandom_range(1)), 50);
      end
    end
  endtask

  // Main sequence: reset, directed ticks, then one random phase per setting.
  initial begin : stimulus
    int p;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_INACTIVITY;
    cfg_wdata  = '0;
    tx_gaps    = 1'b1;
    rx_gaps    = 1'b1;
    sent_count = 0;
    clock_ms   = '0;
    unit_ms    = 64;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed ticks under the reset register values.
    send_tick(make_tick(32'd0, MODE_ECONOMY, OFF, OFF, OFF, OFF, OFF, OFF, OFF));
    send_tick(make_tick(32'd100, MODE_ECONOMY, OFF, OFF, OFF, OFF, OFF, ON, OFF));
    send_tick(make_tick(32'd200, MODE_ECONOMY, OFF, ON, ON, ON, ON, OFF, ON));
    // Low battery is ignored in flight, and every flight indication blocks.
    send_tick(make_tick(32'd300, MODE_PRECISE, OFF, OFF, OFF, OFF, OFF, ON, OFF));
    send_tick(make_tick(32'd400, MODE_FREEFALL, ON, OFF, OFF, OFF, OFF, OFF, OFF));
    send_tick(make_tick(32'd500, MODE_UNUSED, OFF, OFF, OFF, OFF, OFF, OFF, OFF));
    send_tick(make_tick(32'd600, MODE_ECONOMY, ON, OFF, OFF, OFF, OFF, OFF, OFF));
    // Flight ends: grace window opens; its last millisecond, then just after.
    send_tick(make_tick(32'd700, MODE_ECONOMY, OFF, OFF, OFF, OFF, OFF, OFF, OFF));
    send_tick(make_tick(32'd120699, MODE_ECONOMY, OFF, OFF, OFF, OFF, OFF, ON, OFF));
    send_tick(make_tick(32'd120700, MODE_ECONOMY, OFF, OFF, OFF, OFF, OFF, OFF, OFF));
    // Landing delay met exactly, then lock, external power and idle time.
    send_tick(make_tick(32'd300600, MODE_ECONOMY, OFF, OFF, OFF, OFF, OFF, OFF, OFF));
    send_tick(make_tick(32'd300700, MODE_ECONOMY, OFF, OFF, OFF, ON, OFF, OFF, OFF));
    send_tick(make_tick(32'd300800, MODE_ECONOMY, OFF, OFF, OFF, OFF, ON, OFF, OFF));
    send_tick(make_tick(32'd305000, MODE_ECONOMY, OFF, OFF, OFF, OFF, OFF, OFF, OFF));
    send_tick(make_tick(32'd310800, MODE_ECONOMY, OFF, OFF, OFF, OFF, OFF, OFF, OFF));
    send_tick(make_tick(32'd310900, MODE_ECONOMY, OFF, OFF, OFF, OFF, OFF, OFF, ON));
    // Inactivity enabled, landing idle raised to 600000; then time wraps.
    apply_setting(20000, 32'(GRACE_RESET), 32'(LDELAY_RESET), 600000);
    send_tick(make_tick(32'd330900, MODE_ECONOMY, OFF, OFF, OFF, OFF, OFF, OFF, OFF));
    send_tick(make_tick(32'hFFFF_FFFF, MODE_ECONOMY, OFF, OFF, OFF, OFF, OFF, OFF, OFF));
    send_tick(make_tick(32'h0000_0100, MODE_ECONOMY, OFF, OFF, OFF, OFF, OFF, OFF, ON));
    send_tick(make_tick(32'h0000_0200, MODE_PRECISE, OFF, OFF, OFF, OFF, OFF, OFF, OFF));
    send_tick(make_tick(32'h0000_0300, MODE_ECONOMY, OFF, OFF, OFF, OFF, OFF, OFF, OFF));
    // With a zero grace length the armed window blocks nothing.
    apply_setting(20000, 0, 32'(LDELAY_RESET), 600000);
    send_tick(make_tick(32'h0000_0400, MODE_ECONOMY, OFF, OFF, OFF, OFF, OFF, OFF, OFF));

    // Random phases, one per register setting; one phase runs without gaps.
    clock_ms = 32'h0000_0400;
    for (p = 0; p < N_PHASES; p++) begin
      if (p == RANDOM_PHASE) begin
        apply_setting($urandom_range(20000), $urandom_range(6000),
                      $urandom_range(8000), $urandom_range(3000));
      end else begin
        apply_setting(phase_inact[p], phase_grace[p], phase_delay[p], phase_idle[p]);
      end
      tx_gaps = (p != QUIET_PHASE);
      rx_gaps = (p != QUIET_PHASE);
      if ($urandom_range(1)) begin
        clock_ms = 32'hFFFF_FFFF - $urandom_range(20 * unit_ms);
      end
      run_phase(PHASE_TICKS);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d register settings and %0d ticks, %0d of them blocked %s",
             N_PHASES + 3, checked_count, blocked_count, "by flight or grace.");
    $display("Sleep requests seen: %0d low battery, %0d landing, %0d inactivity.",
             low_batt_count, landing_count, inactivity_count);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
rtl/fasc_pkg.sv
rtl/fasc_cfg.sv
rtl/fasc_core.sv
rtl/flight_aware_sleep_controller.sv
verif/fasc_checker.sv
verif/tb_flight_aware_sleep_controller.sv
